### sv/sqch_pkg.sv
`timescale 1ns / 1ps

package sqch_pkg;

    localparam int unsigned CLOCK_HZ = 4194304;

    // Period counters hold at most the longest period plus one item's cycles.
    localparam int CNT_W = $clog2((64'(7) * 64'(CLOCK_HZ)) / 64 + 257);

    localparam logic KIND_ADVANCE = 1'b0;
    localparam logic KIND_LOAD    = 1'b1;

    typedef enum logic [2:0] {
        REG_SWEEP  = 3'd0,
        REG_DUTY   = 3'd1,
        REG_ENV    = 3'd2,
        REG_START  = 3'd3,
        REG_LEN_EN = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic       kind;
        logic [7:0] cycles;
        logic       len_tick;
        logic       trigger;
        logic [5:0] length_value;
    } t_item;

    typedef struct packed {
        logic [5:0]  level;
        logic        active;
        logic [10:0] frequency;
    } t_result;

    typedef struct packed {
        logic [6:0]  sweep_control;
        logic [1:0]  duty_select;
        logic [7:0]  envelope_control;
        logic [10:0] start_frequency;
        logic        length_enable;
    } t_cfg;

    // Sweep period in clock cycles, code in 1/128 s.
    function automatic logic [CNT_W-1:0] sweep_cycles(input logic [2:0] code);
        logic [63:0] p;
        p = (64'(code) * 64'(CLOCK_HZ)) >> 7;
        return p[CNT_W-1:0];
    endfunction

    // Envelope period in clock cycles, code in 1/64 s.
    function automatic logic [CNT_W-1:0] env_cycles(input logic [2:0] code);
        logic [63:0] p;
        p = (64'(code) * 64'(CLOCK_HZ)) >> 6;
        return p[CNT_W-1:0];
    endfunction

    function automatic logic [4:0] duty_threshold(input logic [1:0] sel);
        logic [4:0] t;
        case (sel)
            2'd0:    t = 5'd4;
            2'd1:    t = 5'd8;
            2'd2:    t = 5'd16;
            default: t = 5'd24;
        endcase
        return t;
    endfunction

endpackage

### sv/sqch_chan.sv
`timescale 1ns / 1ps

module sqch_chan (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  sqch_pkg::t_item   i_item,
    input  sqch_pkg::t_cfg    i_cfg,
    output sqch_pkg::t_result o_result
);
    import sqch_pkg::*;

    logic [31:0]      r_pa,     n_pa;
    logic [4:0]       r_duty,   n_duty;
    logic [5:0]       r_len,    n_len;
    logic [3:0]       r_vol,    n_vol;
    logic [2:0]       r_ecode,  n_ecode;
    logic [CNT_W-1:0] r_ecnt,   n_ecnt;
    logic [2:0]       r_scode,  n_scode;
    logic [CNT_W-1:0] r_scnt,   n_scnt;
    logic [11:0]      r_shadow, n_shadow;
    logic [10:0]      r_cur,    n_cur;
    logic             r_on,     n_on;
    logic [5:0]       r_held,   n_held;

    logic [11:0]      period;
    logic [CNT_W-1:0] sstep;
    logic [CNT_W-1:0] estep;
    logic [11:0]      delta;

    always_comb begin
        n_pa     = r_pa;
        n_duty   = r_duty;
        n_len    = r_len;
        n_vol    = r_vol;
        n_ecode  = r_ecode;
        n_ecnt   = r_ecnt;
        n_scode  = r_scode;
        n_scnt   = r_scnt;
        n_shadow = r_shadow;
        n_cur    = r_cur;
        n_on     = r_on;
        n_held   = r_held;
        period   = '0;
        sstep    = '0;
        estep    = '0;
        delta    = '0;

        if (i_item.kind == KIND_LOAD) begin
            n_len = i_item.length_value;
        end else begin
            n_pa = r_pa + 32'(i_item.cycles);

            if (i_cfg.length_enable && i_item.len_tick) begin
                n_len = r_len + 6'd1;
                if (n_len == '0) begin
                    n_on = 1'b0;
                end
            end

            if (i_item.trigger) begin
                n_pa     = '0;
                n_duty   = '0;
                n_ecode  = i_cfg.envelope_control[2:0];
                n_ecnt   = '0;
                n_vol    = i_cfg.envelope_control[7:4];
                n_scode  = i_cfg.sweep_control[6:4];
                n_scnt   = '0;
                n_shadow = {1'b0, i_cfg.start_frequency};
                n_cur    = i_cfg.start_frequency;
                n_on     = 1'b1;
            end

            if (i_cfg.envelope_control[7:3] == '0) begin
                n_on = 1'b0;
            end

            if (n_on) begin
                period = 12'd2048 - {1'b0, n_cur};
                if (n_pa >= 32'(period)) begin
                    n_pa   = n_pa - 32'(period);
                    n_duty = n_duty + 5'd1;
                    if (n_duty > duty_threshold(i_cfg.duty_select)) begin
                        n_held = 6'd16 + 6'(n_vol);
                    end else begin
                        n_held = 6'd16 - 6'(n_vol);
                    end
                end

                sstep = sweep_cycles(n_scode);
                if (sstep != '0) begin
                    n_scnt = n_scnt + CNT_W'(i_item.cycles);
                    if (n_scnt >= sstep) begin
                        n_scnt = n_scnt - sstep;
                        delta  = n_shadow >> i_cfg.sweep_control[2:0];
                        if (i_cfg.sweep_control[3]) begin
                            n_shadow = n_shadow - delta;
                        end else begin
                            n_shadow = n_shadow + delta;
                        end
                        if (n_shadow[11]) begin
                            n_on = 1'b0;
                        end else begin
                            n_cur = n_shadow[10:0];
                        end
                    end
                end

                estep = env_cycles(n_ecode);
                if (estep != '0) begin
                    n_ecnt = n_ecnt + CNT_W'(i_item.cycles);
                    if (n_ecnt >= estep) begin
                        n_ecnt = n_ecnt - estep;
                        if (i_cfg.envelope_control[3]) begin
                            if (n_vol != 4'hF) begin
                                n_vol = n_vol + 4'd1;
                            end
                        end else begin
                            if (n_vol != 4'h0) begin
                                n_vol = n_vol - 4'd1;
                            end
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pa     <= '0;
            r_duty   <= '0;
            r_len    <= '0;
            r_vol    <= '0;
            r_ecode  <= '0;
            r_ecnt   <= '0;
            r_scode  <= '0;
            r_scnt   <= '0;
            r_shadow <= '0;
            r_cur    <= '0;
            r_on     <= 1'b0;
            r_held   <= '0;
        end else if (i_step) begin
            r_pa     <= n_pa;
            r_duty   <= n_duty;
            r_len    <= n_len;
            r_vol    <= n_vol;
            r_ecode  <= n_ecode;
            r_ecnt   <= n_ecnt;
            r_scode  <= n_scode;
            r_scnt   <= n_scnt;
            r_shadow <= n_shadow;
            r_cur    <= n_cur;
            r_on     <= n_on;
            r_held   <= n_held;
        end
    end

    assign o_result.level     = n_held;
    assign o_result.active    = n_on;
    assign o_result.frequency = n_cur;

endmodule

### sv/square_channel_sweep_envelope_top.sv
`timescale 1ns / 1ps

// Square-wave tone channel with frequency sweep, volume envelope and length counter.
// Input stream s_axis: tuser is the item kind (0 advance time, 1 load length
// counter); tdata carries cycles, length tick, trigger and length value.
// Output stream m_axis: one item per input item with level index, active flag
// and current frequency code.
// Config port i_cfg_*: index 0 sweep control, 1 duty select, 2 envelope control,
// 3 start frequency, 4 length enable. o_cfg_ready is always high; write only
// while no item is in flight.
// An accepted item waits in the input register; its result goes into the result
// register once that is free. Throughput: one item per cycle unless the receiver
// stalls; the channel update is combinational between the two registers, which also
// bounds the rate since each item depends on the state the previous one left.
// Receiver stall: the result register holds; the input register still takes
// one more item, then s_axis_tready drops until the result is taken.
// Reset: synchronous, active low; clears the config registers, the channel
// state (silent, frequency zero, level zero) and both valid flags.
module square_channel_sweep_envelope_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // cycles[7:0], len_tick, trigger, length_value[5:0]
    input  logic        s_axis_tuser,  // kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,  // level[5:0], active, frequency[10:0], zero pad
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [10:0] i_cfg_data
);
    import sqch_pkg::*;

    logic    r_in_vld;
    t_item   r_in;
    logic    r_out_vld;
    t_result r_out;
    t_cfg    r_cfg;

    logic    w_out_free;
    logic    w_step;
    logic    w_s_acc;
    t_item   w_item;
    t_result w_res;

    assign w_out_free    = !r_out_vld || m_axis_tready;
    assign w_step        = r_in_vld && w_out_free;
    assign s_axis_tready = !r_in_vld || w_out_free;
    assign w_s_acc       = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    assign w_item.kind         = s_axis_tuser;
    assign w_item.cycles       = s_axis_tdata[7:0];
    assign w_item.len_tick     = s_axis_tdata[8];
    assign w_item.trigger      = s_axis_tdata[9];
    assign w_item.length_value = s_axis_tdata[15:10];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s_acc) begin
            r_in <= w_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_step) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out <= w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_SWEEP:  r_cfg.sweep_control    <= i_cfg_data[6:0];
                REG_DUTY:   r_cfg.duty_select      <= i_cfg_data[1:0];
                REG_ENV:    r_cfg.envelope_control <= i_cfg_data[7:0];
                REG_START:  r_cfg.start_frequency  <= i_cfg_data[10:0];
                REG_LEN_EN: r_cfg.length_enable    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    sqch_chan u_chan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_item   (r_in),
        .i_cfg    (r_cfg),
        .o_result (w_res)
    );

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {6'b0, r_out.frequency, r_out.active, r_out.level};

`ifndef NO_ASSERTIONS
    a_step_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step |=> r_out_vld)
        else $error("processed item left no result");

    a_accept_fills_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s_acc |=> r_in_vld)
        else $error("accepted item not held in input register");

    a_blocked_item_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && !w_out_free) |=> (r_in_vld && $stable(r_in)))
        else $error("waiting input item lost or changed");

    a_result_only_from_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_out_vld && !w_step) |=> !r_out_vld)
        else $error("result appeared without an item");
`endif

endmodule

### dv/square_channel_sweep_envelope_top_tb.sv
`timescale 1ns / 1ps

module square_channel_sweep_envelope_top_tb;
    import sqch_pkg::*;

    localparam int RANDOM_ITEMS = 1650;
    localparam logic [4:0] DUTY_LIMIT [4] = '{5'd4, 5'd8, 5'd16, 5'd24};

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [10:0] i_cfg_data;

    square_channel_sweep_envelope_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // channel mirror
    t_cfg        cfg_shadow;
    logic [31:0] ch_phase;
    logic [4:0]  ch_duty_pos;
    logic [5:0]  ch_length;
    logic [3:0]  ch_volume;
    logic [2:0]  ch_env_code;
    logic [31:0] ch_env_acc;
    logic [2:0]  ch_sweep_code;
    logic [31:0] ch_sweep_acc;
    logic [11:0] ch_shadow_freq;
    logic [10:0] ch_freq;
    logic        ch_on;
    logic [5:0]  ch_level;

    t_result expected_q[$];
    int      error_count;
    int      items_sent;
    int      results_seen;
    int      send_idle_pct;
    int      recv_stall_pct;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch in result %0d, %s: got %0d, expected %0d",
                 results_seen, field, got, want);
        error_count++;
    endtask

    function automatic t_result step_channel(input t_item it);
        t_result     res;
        logic [31:0] period;
        logic [31:0] sweep_len;
        logic [31:0] env_len;
        logic [11:0] delta;
        if (it.kind == KIND_LOAD) begin
            ch_length = it.length_value;
        end else begin
            ch_phase = ch_phase + 32'(it.cycles);
            if (cfg_shadow.length_enable && it.len_tick) begin
                ch_length = ch_length + 6'd1;
                if (ch_length == 6'd0) ch_on = 1'b0;
            end
            if (it.trigger) begin
                ch_phase       = '0;
                ch_duty_pos    = '0;
                ch_env_code    = cfg_shadow.envelope_control[2:0];
                ch_env_acc     = '0;
                ch_volume      = cfg_shadow.envelope_control[7:4];
                ch_sweep_code  = cfg_shadow.sweep_control[6:4];
                ch_sweep_acc   = '0;
                ch_shadow_freq = {1'b0, cfg_shadow.start_frequency};
                ch_freq        = cfg_shadow.start_frequency;
                ch_on          = 1'b1;
            end
            if (cfg_shadow.envelope_control[7:3] == 5'd0) ch_on = 1'b0;
            if (ch_on) begin
                period = 32'd2048 - 32'(ch_freq);
                if (ch_phase >= period) begin
                    ch_phase    = ch_phase - period;
                    ch_duty_pos = ch_duty_pos + 5'd1;
                    if (ch_duty_pos > DUTY_LIMIT[cfg_shadow.duty_select])
                        ch_level = 6'd16 + 6'(ch_volume);
                    else
                        ch_level = 6'd16 - 6'(ch_volume);
                end
                sweep_len = 32'((64'(ch_sweep_code) * 64'(CLOCK_HZ)) / 64'd128);
                if (sweep_len != 0) begin
                    ch_sweep_acc = ch_sweep_acc + 32'(it.cycles);
                    if (ch_sweep_acc >= sweep_len) begin
                        ch_sweep_acc = ch_sweep_acc - sweep_len;
                        delta = ch_shadow_freq >> cfg_shadow.sweep_control[2:0];
                        if (cfg_shadow.sweep_control[3])
                            ch_shadow_freq = ch_shadow_freq - delta;
                        else
                            ch_shadow_freq = ch_shadow_freq + delta;
                        if (ch_shadow_freq[11])
                            ch_on = 1'b0;
                        else
                            ch_freq = ch_shadow_freq[10:0];
                    end
                end
                env_len = 32'((64'(ch_env_code) * 64'(CLOCK_HZ)) / 64'd64);
                if (env_len != 0) begin
                    ch_env_acc = ch_env_acc + 32'(it.cycles);
                    if (ch_env_acc >= env_len) begin
                        ch_env_acc = ch_env_acc - env_len;
                        if (cfg_shadow.envelope_control[3]) begin
                            if (ch_volume != 4'hF) ch_volume = ch_volume + 4'd1;
                        end else begin
                            if (ch_volume != 4'h0) ch_volume = ch_volume - 4'd1;
                        end
                    end
                end
            end
        end
        res.level     = ch_level;
        res.active    = ch_on;
        res.frequency = ch_freq;
        return res;
    endfunction

    function automatic t_item make_item(input logic kind, input logic [7:0] cycles,
                                        input logic tick, input logic trig,
                                        input logic [5:0] lval);
        t_item it;
        it.kind         = kind;
        it.cycles       = cycles;
        it.len_tick     = tick;
        it.trigger      = trig;
        it.length_value = lval;
        return it;
    endfunction

    task automatic send_item(input t_item it);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = it.kind;
        s_axis_tdata  = {it.length_value, it.trigger, it.len_tick, it.cycles};
        do @(posedge i_clk); while (!s_axis_tready);
        expected_q.push_back(step_channel(it));
        items_sent++;
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
    endtask

    task automatic wait_drain();
        while (expected_q.size() != 0) @(negedge i_clk);
    endtask

    // registers change only with nothing in flight
    task automatic write_reg(input t_reg_idx idx, input logic [10:0] val);
        wait_drain();
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_SWEEP:  cfg_shadow.sweep_control    = val[6:0];
            REG_DUTY:   cfg_shadow.duty_select      = val[1:0];
            REG_ENV:    cfg_shadow.envelope_control = val[7:0];
            REG_START:  cfg_shadow.start_frequency  = val;
            REG_LEN_EN: cfg_shadow.length_enable    = val[0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            m_axis_tready = (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        t_result got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.level     = m_axis_tdata[5:0];
            got.active    = m_axis_tdata[6];
            got.frequency = m_axis_tdata[17:7];
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected item", 32'(m_axis_tdata), 0);
            end else begin
                want = expected_q.pop_front();
                if (got.level !== want.level)
                    report_mismatch("level", 32'(got.level), 32'(want.level));
                if (got.active !== want.active)
                    report_mismatch("active", 32'(got.active), 32'(want.active));
                if (got.frequency !== want.frequency)
                    report_mismatch("frequency", 32'(got.frequency), 32'(want.frequency));
            end
            results_seen++;
        end
    end

    task automatic test_length_and_load();
        write_reg(REG_ENV, 11'h0F0);
        write_reg(REG_START, 11'd2047);
        write_reg(REG_LEN_EN, 11'd1);
        write_reg(REG_DUTY, 11'd0);
        write_reg(REG_SWEEP, 11'd0);
        // load ignores cycles, tick and trigger
        send_item(make_item(KIND_LOAD, 8'd255, 1'b1, 1'b1, 6'd63));
        send_item(make_item(KIND_ADVANCE, 8'd0, 1'b0, 1'b1, 6'd0));
        // length wrap silences the channel, level holds
        send_item(make_item(KIND_ADVANCE, 8'd255, 1'b1, 1'b0, 6'd0));
        send_item(make_item(KIND_ADVANCE, 8'd255, 1'b0, 1'b0, 6'd21));
        send_item(make_item(KIND_LOAD, 8'd0, 1'b0, 1'b0, 6'd63));
        // wrap and trigger together: trigger wins
        send_item(make_item(KIND_ADVANCE, 8'd1, 1'b1, 1'b1, 6'd42));
        send_item(make_item(KIND_LOAD, 8'd170, 1'b0, 1'b0, 6'd0));
    endtask

    task automatic test_trigger_and_duty();
        write_reg(REG_LEN_EN, 11'd0);
        send_item(make_item(KIND_ADVANCE, 8'd0, 1'b1, 1'b1, 6'd0));
        repeat (6) send_item(make_item(KIND_ADVANCE, 8'd255, 1'b1, 1'b0, 6'd0));
        // duty is read live
        write_reg(REG_DUTY, 11'd3);
        repeat (2) send_item(make_item(KIND_ADVANCE, 8'd128, 1'b0, 1'b0, 6'd0));
        write_reg(REG_DUTY, 11'd2);
        send_item(make_item(KIND_ADVANCE, 8'd85, 1'b0, 1'b0, 6'd0));
    endtask

    task automatic test_envelope_disable();
        write_reg(REG_ENV, 11'h000);
        send_item(make_item(KIND_ADVANCE, 8'd10, 1'b0, 1'b1, 6'd0));
        write_reg(REG_ENV, 11'h008);
        send_item(make_item(KIND_ADVANCE, 8'd10, 1'b0, 1'b1, 6'd0));
        write_reg(REG_ENV, 11'h007);
        send_item(make_item(KIND_ADVANCE, 8'd10, 1'b0, 1'b1, 6'd0));
    endtask

    // One triggered note with random setup; at random, a live register change halfway.
    task automatic play_note(input int n_items);
        logic [2:0]  code;
        logic [6:0]  sweep;
        logic [7:0]  env;
        logic [10:0] start;
        logic [10:0] val;
        logic [7:0]  cyc;
        t_reg_idx    idx;
        int          pick;
        code  = ($urandom_range(3) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(2, 1));
        sweep = {code, 1'($urandom_range(1)), 3'($urandom_range(7))};
        pick  = $urandom_range(15);
        if (pick == 0) sweep = 7'h00;
        if (pick == 1) sweep = 7'h7F;
        code = ($urandom_range(3) == 0) ? 3'($urandom_range(7)) : 3'd1;
        env  = {4'($urandom_range(15)), 1'($urandom_range(1)), code};
        pick = $urandom_range(15);
        if (pick == 0) env = 8'h00;
        if (pick == 1) env = 8'hFF;
        if (pick == 2) env = 8'($urandom_range(7));
        start = 11'($urandom_range(2047));
        pick  = $urandom_range(7);
        if (pick == 0) start = 11'd0;
        if (pick == 1) start = 11'd2047;
        write_reg(REG_SWEEP, 11'(sweep));
        write_reg(REG_DUTY, 11'($urandom_range(3)));
        write_reg(REG_ENV, 11'(env));
        write_reg(REG_START, start);
        write_reg(REG_LEN_EN, 11'($urandom_range(1)));
        send_item(make_item(KIND_ADVANCE, 8'($urandom_range(255)), 1'b0, 1'b1, 6'd0));
        for (int i = 1; i < n_items; i++) begin
            if (i == n_items / 2 && $urandom_range(1) == 1) begin
                idx = t_reg_idx'($urandom_range(4));
                case (idx)
                    REG_SWEEP: val = 11'($urandom_range(127));
                    REG_DUTY:  val = 11'($urandom_range(3));
                    REG_ENV:   val = 11'($urandom_range(255));
                    REG_START: val = 11'($urandom_range(2047));
                    default:   val = 11'($urandom_range(1));
                endcase
                write_reg(idx, val);
            end
            cyc = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(255, 160));
            if ($urandom_range(99) < 4)
                send_item(make_item(KIND_LOAD, 8'($urandom_range(255)), 1'($urandom_range(1)),
                                    1'($urandom_range(1)), 6'($urandom_range(63))));
            else
                send_item(make_item(KIND_ADVANCE, cyc, 1'($urandom_range(15) == 0),
                                    1'($urandom_range(63) == 0), 6'($urandom_range(63))));
        end
    endtask

    task automatic test_random_notes(input int idle_pct, input int stall_pct, input int quota);
        int first;
        int n;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        first = items_sent;
        while (items_sent - first < quota) begin
            n = $urandom_range(30, 420);
            if (n > quota - (items_sent - first)) n = quota - (items_sent - first);
            play_note(n);
        end
    endtask

    initial begin
        i_rst_n        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = '0;
        i_cfg_data     = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        error_count    = 0;
        items_sent     = 0;
        results_seen   = 0;
        cfg_shadow     = '0;
        ch_phase       = '0;
        ch_duty_pos    = '0;
        ch_length      = '0;
        ch_volume      = '0;
        ch_env_code    = '0;
        ch_env_acc     = '0;
        ch_sweep_code  = '0;
        ch_sweep_acc   = '0;
        ch_shadow_freq = '0;
        ch_freq        = '0;
        ch_on          = 1'b0;
        ch_level       = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_length_and_load();
        test_trigger_and_duty();
        test_envelope_disable();
        test_random_notes(0, 0, RANDOM_ITEMS / 4);
        test_random_notes(53, 0, RANDOM_ITEMS / 4);
        test_random_notes(0, 53, RANDOM_ITEMS / 4);
        test_random_notes(19, 19, RANDOM_ITEMS / 4);

        wait_drain();
        repeat (10) @(posedge i_clk);
        if (error_count == 0 && expected_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
